FILE: sv/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the spike encoder
// Window geometry, kernel ROM, adder widths, beat and control structs.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // window geometry
    localparam int WINDOW_TAPS = 24;
    localparam int FILL_W      = $clog2(WINDOW_TAPS);
    localparam int TIME_BITS   = 16;

    // data widths
    localparam int RES_W      = 32;
    localparam int KERNEL_W   = 13;
    localparam int ABS_W      = 32;
    localparam int GROUP      = 4;
    localparam int GROUPS     = WINDOW_TAPS / GROUP;
    localparam int PART_W     = ABS_W + $clog2(GROUP);
    localparam int SUM_W      = ABS_W + $clog2(WINDOW_TAPS);
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 24;
    localparam int REP_W      = 5;
    localparam int REP_MAX    = 16;
    localparam int LEFT_W     = 6;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [REP_W-1:0]     RST_REPEAT     = REP_W'(10);
    localparam logic [TIME_BITS-1:0] RST_TIME_LIMIT = TIME_BITS'(65535);
    localparam logic [THR_W-1:0]     RST_THRESHOLD  = THR_W'(39322);
    localparam logic [GAIN_W-1:0]    RST_GAIN       = GAIN_W'(2000);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT     = 2'd0,
        CFG_TIME_LIMIT = 2'd1,
        CFG_THRESHOLD  = 2'd2,
        CFG_GAIN       = 2'd3
    } t_cfg_idx;

    // normalized gaussian kernel, Q0.16, centre at tap 12
    localparam logic [KERNEL_W-1:0] KERNEL [WINDOW_TAPS] = '{
        13'd23,   13'd58,   13'd136,  13'd290,  13'd572,  13'd1042,
        13'd1753, 13'd2723, 13'd3902, 13'd5163, 13'd6306, 13'd7110,
        13'd7400, 13'd7110, 13'd6306, 13'd5163, 13'd3902, 13'd2723,
        13'd1753, 13'd1042, 13'd572,  13'd290,  13'd136,  13'd58
    };

    // input beat
    typedef struct packed {
        logic signed [RES_W-1:0] sample;
        logic [7:0]              channel;
        logic                    end_of_record;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [7:0]           channel_out;
        logic [TIME_BITS-1:0] step_stamp;
        logic                 spike;
        logic                 last;
    } t_out_beat;

    // per-cell control
    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
        logic fire;
    } t_cell_ctrl;

endpackage

FILE: sv/bsa_cell.sv
// ----------------------------------------------------------------------------
// bsa_cell: one residual tap of the window
// Holds one residual, forms its error terms and hands its updated value
// to the left neighbor when the window advances.
// ----------------------------------------------------------------------------
module bsa_cell
    import bsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctrl              i_ctrl,
    input  logic signed [RES_W-1:0] i_load_val,
    input  logic signed [RES_W-1:0] i_nbr_post,
    input  logic [KERNEL_W-1:0]     i_kernel,
    output logic signed [RES_W-1:0] o_post,
    output logic [ABS_W-1:0]        o_dabs,
    output logic [ABS_W-1:0]        o_rabs
);

    logic signed [RES_W-1:0] r_res;
    logic signed [RES_W-1:0] r_sub;
    logic [ABS_W-1:0]        r_dabs;
    logic [ABS_W-1:0]        r_rabs;
    logic signed [RES_W:0]   w_diff;
    logic [RES_W:0]          w_neg;
    logic signed [RES_W-1:0] w_sat;

    // residual minus kernel, one extra bit
    assign w_diff = {r_res[RES_W-1], r_res} - {{(RES_W + 1 - KERNEL_W){1'b0}}, i_kernel};
    assign w_neg  = -w_diff;

    // saturate back to the residual range
    always_comb begin
        if (w_diff[RES_W] != w_diff[RES_W-1]) begin
            w_sat = w_diff[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
        end else begin
            w_sat = w_diff[RES_W-1:0];
        end
    end

    // residual tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_res <= '0;
        end else if (i_ctrl.shift) begin
            r_res <= i_nbr_post;
        end else if (i_ctrl.load) begin
            r_res <= i_load_val;
        end
    end

    // error terms and subtracted value, registered
    always_ff @(posedge i_clk) begin
        r_sub  <= w_sat;
        r_dabs <= w_diff[RES_W] ? w_neg[ABS_W-1:0] : w_diff[ABS_W-1:0];
        r_rabs <= r_res[RES_W-1] ? ABS_W'(~r_res + 1'b1) : ABS_W'(r_res);
    end

    // value handed to the neighbor on a window advance
    assign o_post = i_ctrl.fire ? r_sub : r_res;
    assign o_dabs = r_dabs;
    assign o_rabs = r_rabs;

endmodule

FILE: sv/bsa_sum.sv
// ----------------------------------------------------------------------------
// bsa_sum: registered adder tree over the cell error terms
// Two levels: groups of four taps, then the group totals plus threshold.
// ----------------------------------------------------------------------------
module bsa_sum
    import bsa_pkg::*;
(
    input  logic             i_clk,
    input  logic [ABS_W-1:0] i_dabs [WINDOW_TAPS],
    input  logic [ABS_W-1:0] i_rabs [WINDOW_TAPS],
    input  logic [THR_W-1:0] i_threshold,
    output logic [SUM_W-1:0] o_e1t,
    output logic [SUM_W-1:0] o_e2
);

    logic [PART_W-1:0] w_dpart [GROUPS];
    logic [PART_W-1:0] w_rpart [GROUPS];
    logic [PART_W-1:0] r_dpart [GROUPS];
    logic [PART_W-1:0] r_rpart [GROUPS];
    logic [SUM_W-1:0]  w_e1t;
    logic [SUM_W-1:0]  w_e2;
    logic [SUM_W-1:0]  r_e1t;
    logic [SUM_W-1:0]  r_e2;

    // first level: four taps per group
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            w_dpart[g] = '0;
            w_rpart[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                w_dpart[g] = w_dpart[g] + PART_W'(i_dabs[g*GROUP + k]);
                w_rpart[g] = w_rpart[g] + PART_W'(i_rabs[g*GROUP + k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dpart <= w_dpart;
        r_rpart <= w_rpart;
    end

    // second level: group totals, threshold folded into the error side
    always_comb begin
        w_e1t = SUM_W'(i_threshold);
        w_e2  = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_e1t = w_e1t + SUM_W'(r_dpart[g]);
            w_e2  = w_e2 + SUM_W'(r_rpart[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1t <= w_e1t;
        r_e2  <= w_e2;
    end

    assign o_e1t = r_e1t;
    assign o_e2  = r_e2;

endmodule

FILE: sv/bsa_spike_encoder_unit.sv
// ----------------------------------------------------------------------------
// bsa_spike_encoder_unit: one channel of the BSA spike encoder, top level
// Per item: accept, multiply, then a push per fine step while the window only
// fills; once it is full, each fine step pushes, forms error terms, passes the
// two adder levels and applies its decision; the item then finishes. End of
// record adds pushes that flush the window. Output stalls hold the apply step.
// Synchronous active-low reset restores register defaults and clears the window.
// ----------------------------------------------------------------------------
module bsa_spike_encoder_unit
    import bsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MULT  = 8'b0000_0010,
        ST_PUSH  = 8'b0000_0100,
        ST_ABS   = 8'b0000_1000,
        ST_PART  = 8'b0001_0000,
        ST_SUM   = 8'b0010_0000,
        ST_APPLY = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [REP_W-1:0]     r_cfg_repeat;
    logic [TIME_BITS-1:0] r_cfg_time_limit;
    logic [THR_W-1:0]     r_cfg_threshold;
    logic [GAIN_W-1:0]    r_cfg_gain;

    // item context
    logic signed [RES_W-1:0]          r_sample;
    logic [7:0]                       r_channel;
    logic                             r_eor;
    logic signed [RES_W+GAIN_W:0]     r_prod;
    logic signed [RES_W+GAIN_W:0]     w_prod;
    logic signed [RES_W-1:0]          w_scaled;
    logic signed [RES_W-1:0]          w_push_val;
    logic [LEFT_W-1:0]                r_left;
    logic [REP_W-1:0]                 r_rep_left;
    logic [REP_W-1:0]                 w_rf;
    logic [FILL_W-1:0]                r_fill;
    logic [TIME_BITS-1:0]             r_time;
    logic [TIME_BITS-1:0]             w_tnext;

    // output stage
    logic      r_out_valid;
    t_out_beat r_out_beat;
    logic      w_out_free;
    logic      w_apply;
    logic      w_fire;

    // cell row and tree
    t_cell_ctrl              w_ctrl [WINDOW_TAPS];
    logic signed [RES_W-1:0] w_post [WINDOW_TAPS+1];
    logic [ABS_W-1:0]        w_dabs [WINDOW_TAPS];
    logic [ABS_W-1:0]        w_rabs [WINDOW_TAPS];
    logic [SUM_W-1:0]        w_e1t;
    logic [SUM_W-1:0]        w_e2;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_repeat     <= RST_REPEAT;
            r_cfg_time_limit <= RST_TIME_LIMIT;
            r_cfg_threshold  <= RST_THRESHOLD;
            r_cfg_gain       <= RST_GAIN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REPEAT:     r_cfg_repeat     <= i_cfg_data[REP_W-1:0];
                CFG_TIME_LIMIT: r_cfg_time_limit <= i_cfg_data[TIME_BITS-1:0];
                CFG_THRESHOLD:  r_cfg_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_GAIN:       r_cfg_gain       <= i_cfg_data[GAIN_W-1:0];
                default:        r_cfg_repeat     <= r_cfg_repeat;
            endcase
        end
    end

    // effective repeat factor, clamped to 1..16
    always_comb begin
        if (r_cfg_repeat == '0) begin
            w_rf = REP_W'(1);
        end else if (r_cfg_repeat > REP_W'(REP_MAX)) begin
            w_rf = REP_W'(REP_MAX);
        end else begin
            w_rf = r_cfg_repeat;
        end
    end

    // gain multiply and saturation
    assign w_prod = r_sample * $signed({1'b0, r_cfg_gain});

    always_comb begin
        if (r_prod[RES_W+GAIN_W:RES_W-1] == {(GAIN_W+2){r_prod[RES_W-1]}}) begin
            w_scaled = r_prod[RES_W-1:0];
        end else if (r_prod[RES_W+GAIN_W]) begin
            w_scaled = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            w_scaled = {1'b0, {(RES_W-1){1'b1}}};
        end
    end

    assign w_push_val = (r_rep_left != '0) ? w_scaled : '0;

    // decision and handshake terms
    assign w_fire     = w_e1t < w_e2;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_apply    = (r_state == ST_APPLY) && w_out_free;
    assign w_tnext    = (r_time == '1) ? r_time : r_time + 1'b1;
    assign o_in_stall = (r_state != ST_IDLE);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_MULT;
            ST_MULT:  n_state = ST_PUSH;
            ST_PUSH: begin
                if (r_fill == FILL_W'(WINDOW_TAPS - 1)) begin
                    n_state = ST_ABS;
                end else if (r_left == LEFT_W'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_ABS:   n_state = ST_PART;
            ST_PART:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_APPLY;
            ST_APPLY: begin
                if (w_out_free) begin
                    n_state = (r_left == '0) ? ST_FIN : ST_PUSH;
                end
            end
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item context, counters and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_rep_left <= '0;
            r_fill     <= '0;
            r_time     <= '0;
            r_eor      <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_eor      <= i_in_beat.end_of_record;
                        r_rep_left <= w_rf;
                        r_left     <= LEFT_W'(w_rf)
                                    + (i_in_beat.end_of_record ? LEFT_W'(WINDOW_TAPS - 1) : '0);
                    end
                end
                ST_PUSH: begin
                    r_left <= r_left - 1'b1;
                    if (r_rep_left != '0) begin
                        r_rep_left <= r_rep_left - 1'b1;
                    end
                    if (r_fill != FILL_W'(WINDOW_TAPS - 1)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                ST_APPLY: begin
                    if (w_out_free) begin
                        r_time <= w_tnext;
                    end
                end
                ST_FIN: begin
                    if (r_eor) begin
                        r_fill <= '0;
                        r_time <= '0;
                    end
                end
                default: r_left <= r_left;
            endcase
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_sample  <= i_in_beat.sample;
            r_channel <= i_in_beat.channel;
        end
        if (r_state == ST_MULT) begin
            r_prod <= w_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_beat.channel_out <= r_channel;
            r_out_beat.step_stamp  <= w_tnext;
            r_out_beat.spike       <= w_fire && (w_tnext < r_cfg_time_limit);
            r_out_beat.last        <= (r_left == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // row of residual cells, each takes its right neighbor on advance
    assign w_post[WINDOW_TAPS] = '0;

    for (genvar j = 0; j < WINDOW_TAPS; j++) begin : g_cell
        always_comb begin
            w_ctrl[j].load  = (r_state == ST_PUSH) && (r_fill == FILL_W'(j));
            w_ctrl[j].shift = w_apply;
            w_ctrl[j].clear = (r_state == ST_FIN) && r_eor;
            w_ctrl[j].fire  = w_fire;
        end

        bsa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[j]),
            .i_load_val (w_push_val),
            .i_nbr_post (w_post[j+1]),
            .i_kernel   (KERNEL[j]),
            .o_post     (w_post[j]),
            .o_dabs     (w_dabs[j]),
            .o_rabs     (w_rabs[j])
        );
    end

    // error sums
    bsa_sum u_sum (
        .i_clk       (i_clk),
        .i_dabs      (w_dabs),
        .i_rabs      (w_rabs),
        .i_threshold (r_cfg_threshold),
        .o_e1t       (w_e1t),
        .o_e2        (w_e2)
    );

`ifndef ASSERT_OFF
    // an applied decision always leaves a beat in the output register
    a_apply_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |=> o_out_valid)
        else $error("decision applied without output beat");

    // no pushes remain once the sequencer is back at rest
    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_left == '0))
        else $error("idle with pushes outstanding");

    // a decision is only evaluated on a full window
    a_eval_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ABS) |-> (r_fill == FILL_W'(WINDOW_TAPS - 1)))
        else $error("decision on a window that is not full");
`endif

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for bsa_spike_encoder_unit
// Sample beats are queued by the stimulus process and presented by a clocked
// driver. Every accepted beat runs through a local fixed-point model of the
// encoder, and its decisions are queued in order. A clocked monitor checks
// each result beat field by field against that queue. The run covers
// directed corner records, randomized records under random register
// settings, and a closing record without idling at the largest repeat factor.
// ----------------------------------------------------------------------------
module tb;
    import bsa_pkg::*;

    localparam int      CLK_HALF      = 4;
    localparam int      SETTLE_CYCLES = 3 + 5 * REP_MAX + 115 + 50;
    localparam int      CYCLE_LIMIT   = 3_000_000;
    localparam int      LONG_ITEMS    = 31;
    localparam longint  TIME_MAX      = (longint'(1) << TIME_BITS) - 1;
    localparam longint  GAUSS_Q16 [13] = '{
        65536, 62966, 55846, 45723, 34557, 24110, 15527, 9231, 5066, 2567, 1200,
        518, 207
    };

    // dut ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_REPEAT;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_beat   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_beat;

    // stimulus and expectation stores
    t_in_beat    sample_queue[$];
    t_out_beat   pending_decisions[$];
    bit          idle_on = 1'b1;
    int          in_gap  = 0;
    int          out_gap = 0;

    // encoder model state and registers
    longint      kern_q16 [WINDOW_TAPS];
    int          resid    [WINDOW_TAPS];
    longint      step_time;
    int          fill_n;
    int          rep_reg;
    longint      limit_reg;
    longint      thr_reg;
    longint      gain_reg;
    t_out_beat   held_dec;
    bit          held_valid;

    // statistics
    int unsigned cycle_count  = 0;
    int          mismatches   = 0;
    int          n_samples    = 0;
    int          n_checked    = 0;
    int          n_spikes     = 0;
    int          n_late_fires = 0;
    int          n_res_sat    = 0;
    int          n_time_sat   = 0;

    bsa_spike_encoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int clip32(input longint x);
        if (x > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (x < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
        return int'(x);
    endfunction

    // one push into the residual window, deciding the oldest step once full
    task automatic push_window(input int v, input logic [7:0] ch);
        longint    e1;
        longint    e2;
        longint    r;
        longint    d;
        longint    t;
        bit        fire;
        t_out_beat res;
        if (fill_n >= WINDOW_TAPS) fill_n = WINDOW_TAPS - 1;
        resid[fill_n] = v;
        fill_n++;
        if (fill_n == WINDOW_TAPS) begin
            e1 = 0;
            e2 = 0;
            for (int j = 0; j < WINDOW_TAPS; j++) begin
                r = resid[j];
                d = r - kern_q16[j];
                e1 += (d < 0) ? -d : d;
                e2 += (r < 0) ? -r : r;
            end
            fire = (e1 + thr_reg) < e2;
            // subtract the kernel with saturation on a fire
            if (fire) begin
                for (int j = 0; j < WINDOW_TAPS; j++) begin
                    d = longint'(resid[j]) - kern_q16[j];
                    if (d != longint'(clip32(d))) n_res_sat++;
                    resid[j] = clip32(d);
                end
            end
            if (step_time >= TIME_MAX) begin
                t = TIME_MAX;
                n_time_sat++;
            end else begin
                t = step_time + 1;
            end
            res             = '0;
            res.channel_out = ch;
            res.step_stamp  = t[TIME_BITS-1:0];
            res.spike       = fire && (t < limit_reg);
            if (fire && !res.spike) n_late_fires++;
            step_time = t;
            // hold one decision back so the item's final one can be marked
            if (held_valid) pending_decisions = {pending_decisions, held_dec};
            held_dec   = res;
            held_valid = 1'b1;
            // oldest step leaves the window
            for (int j = 0; j + 1 < WINDOW_TAPS; j++) resid[j] = resid[j + 1];
            resid[WINDOW_TAPS-1] = 0;
            fill_n = WINDOW_TAPS - 1;
        end
    endtask

    // expected decisions of one accepted sample beat
    task automatic encode_sample(input t_in_beat b);
        longint s;
        int     scaled;
        int     rf;
        s      = $signed(b.sample);
        scaled = clip32(s * gain_reg);
        rf     = rep_reg;
        if (rf == 0) rf = 1;
        if (rf > REP_MAX) rf = REP_MAX;
        held_valid = 1'b0;
        n_samples++;
        for (int k = 0; k < rf; k++) push_window(scaled, b.channel);
        // end of record: flush zeros, then start clean
        if (b.end_of_record) begin
            for (int k = 0; k + 1 < WINDOW_TAPS; k++) push_window(0, b.channel);
            foreach (resid[j]) resid[j] = 0;
            fill_n    = 0;
            step_time = 0;
        end
        if (held_valid) begin
            held_dec.last = 1'b1;
            pending_decisions = {pending_decisions, held_dec};
        end
    endtask

    // input driver: a beat stays up until taken, gaps only between beats
    always @(posedge i_clk) begin : drive_samples
        bit held;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            held = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                encode_sample(i_in_beat);
                held = 1'b0;
            end
            if (!held) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() != 0 && idle_on &&
                             $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 4);
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    i_in_beat  <= sample_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result-side backpressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            out_gap = 0;
            i_out_stall <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_decisions
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_out_beat.spike === 1'b1) n_spikes++;
            if (pending_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected decision beat: ch %0d t %0d spike %0b last %0b",
                             o_out_beat.channel_out, o_out_beat.step_stamp,
                             o_out_beat.spike, o_out_beat.last);
            end else begin
                want = pending_decisions.pop_front();
                n_checked++;
                if (o_out_beat.channel_out !== want.channel_out ||
                    o_out_beat.step_stamp  !== want.step_stamp  ||
                    o_out_beat.spike       !== want.spike       ||
                    o_out_beat.last        !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"decision mismatch: expected ch %0d t %0d spike %0b ",
                                  "last %0b, got ch %0d t %0d spike %0b last %0b"},
                                 want.channel_out, want.step_stamp, want.spike, want.last,
                                 o_out_beat.channel_out, o_out_beat.step_stamp,
                                 o_out_beat.spike, o_out_beat.last);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bsa_spike_encoder_unit regression: fail");
            $finish;
        end
    end

    // register write, mirrored into the model
    task automatic set_reg(input t_cfg_idx idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_REPEAT:     rep_reg   = int'(val & 32'h1F);
            CFG_TIME_LIMIT: limit_reg = longint'(val & 32'hFFFF);
            CFG_THRESHOLD:  thr_reg   = longint'(val & 32'hFF_FFFF);
            CFG_GAIN:       gain_reg  = longint'(val & 32'hFFFF);
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [31:0] smp, input logic [7:0] ch, input logic eor);
        t_in_beat b;
        b.sample        = smp;
        b.channel       = ch;
        b.end_of_record = eor;
        sample_queue = {sample_queue, b};
    endtask

    // wait until every beat is taken and every decision seen, then let it settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || i_in_valid || pending_decisions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            7:       return 32'($urandom_range(0, 262144)) - 32'd131072;
            8:       return $urandom;
            9:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 24)) - 32'd6;
        endcase
    endfunction

    // one phase of random records under random register settings
    task automatic random_phase(input int n);
        int          v;
        int          left;
        logic [7:0]  ch;
        logic        eor;
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = $urandom_range(17, 31);
            2:       v = REP_MAX;
            default: v = $urandom_range(1, 6);
        endcase
        set_reg(CFG_REPEAT, v);
        case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(1, 600);
        endcase
        set_reg(CFG_TIME_LIMIT, v);
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 24'hFF_FFFF;
            2:       v = $urandom_range(0, 24'hFF_FFFF);
            default: v = $urandom_range(0, 80000);
        endcase
        set_reg(CFG_THRESHOLD, v);
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 65535;
            2:       v = $urandom_range(0, 65535);
            default: v = $urandom_range(500, 4000);
        endcase
        set_reg(CFG_GAIN, v);
        idle_on = ($urandom_range(0, 3) != 0);
        left = $urandom_range(1, 24);
        ch   = 8'($urandom);
        for (int k = 0; k < n; k++) begin
            // mostly whole records, sometimes a stray end marker or channel
            eor = (left == 0) || ($urandom_range(0, 24) == 0);
            if ($urandom_range(0, 7) == 0) ch = 8'($urandom);
            queue_item(rand_sample(), ch, eor);
            if (eor) begin
                left = $urandom_range(1, 24);
                ch   = 8'($urandom);
            end else begin
                left--;
            end
        end
        wait_drained();
    endtask

    // stimulus
    initial begin
        longint g [WINDOW_TAPS];
        longint gsum;
        int     d;

        // normalized gaussian kernel and model reset state
        gsum = 0;
        for (int i = 0; i < WINDOW_TAPS; i++) begin
            d    = (i >= WINDOW_TAPS / 2) ? i - WINDOW_TAPS / 2 : WINDOW_TAPS / 2 - i;
            g[i] = (d < 13) ? GAUSS_Q16[d] : 0;
            gsum += g[i];
        end
        if (gsum == 0) gsum = 1;
        for (int i = 0; i < WINDOW_TAPS; i++)
            kern_q16[i] = ((g[i] << 16) + gsum / 2) / gsum;
        foreach (resid[j]) resid[j] = 0;
        step_time  = 0;
        fill_n     = 0;
        rep_reg    = int'(RST_REPEAT);
        limit_reg  = longint'(RST_TIME_LIMIT);
        thr_reg    = longint'(RST_THRESHOLD);
        gain_reg   = longint'(RST_GAIN);
        held_valid = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero, small values, both sample extremes, end of record
        queue_item(32'h0000_0000, 8'h00, 1'b0);
        queue_item(32'h0000_0003, 8'h5A, 1'b0);
        queue_item(32'h0000_0006, 8'hA5, 1'b0);
        queue_item(32'h7FFF_FFFF, 8'hFF, 1'b0);
        queue_item(32'h8000_0000, 8'h01, 1'b0);
        queue_item(32'hFFFF_FFFE, 8'h80, 1'b1);
        wait_drained();

        // full gain saturates samples, a negative burst saturates the residuals,
        // and an early time limit suppresses the late spikes
        set_reg(CFG_REPEAT, 2);
        set_reg(CFG_GAIN, 65535);
        set_reg(CFG_THRESHOLD, 0);
        set_reg(CFG_TIME_LIMIT, 20);
        for (int k = 0; k < 11; k++) queue_item(32'h7FFF_FFFF, 8'(k), 1'b0);
        queue_item(32'h8000_0000, 8'hC3, 1'b0);
        queue_item(32'h7FFF_FFFF, 8'h3C, 1'b0);
        queue_item(32'h7FFF_FFFF, 8'h7E, 1'b0);
        queue_item(32'h4000_0000, 8'hE7, 1'b1);
        wait_drained();

        // repeat of zero acts as one; zero gain and the widest threshold
        set_reg(CFG_REPEAT, 0);
        set_reg(CFG_GAIN, 0);
        set_reg(CFG_THRESHOLD, 24'hFF_FFFF);
        queue_item($urandom, 8'h11, 1'b0);
        queue_item($urandom, 8'h22, 1'b0);
        queue_item($urandom, 8'h44, 1'b1);
        wait_drained();

        // repeat above range acts as sixteen; unit gain, time limit of zero
        set_reg(CFG_REPEAT, 31);
        set_reg(CFG_GAIN, 1);
        set_reg(CFG_THRESHOLD, 0);
        set_reg(CFG_TIME_LIMIT, 0);
        queue_item(32'h7FFF_FFFF, 8'h99, 1'b0);
        queue_item(32'h0001_0000, 8'h66, 1'b1);
        wait_drained();

        // randomized records
        for (int p = 0; p < 5; p++) random_phase(30);

        // closing record without idling at the largest repeat factor
        idle_on = 1'b0;
        set_reg(CFG_REPEAT, REP_MAX);
        set_reg(CFG_GAIN, 2000);
        set_reg(CFG_THRESHOLD, 39322);
        set_reg(CFG_TIME_LIMIT, 65535);
        for (int k = 0; k < LONG_ITEMS; k++)
            queue_item(32'($urandom_range(0, 24)) - 32'd6, 8'h5C, k == LONG_ITEMS - 1);
        // a short record after it starts from time zero again
        for (int k = 0; k < 3; k++)
            queue_item(32'($urandom_range(0, 24)) - 32'd6, 8'hA3, k == 2);
        wait_drained();

        $display("covered %0d sample beats and %0d checked decisions, %0d of them spikes",
                 n_samples, n_checked, n_spikes);
        $display("%0d fires past the time limit, %0d saturated residuals, %0d saturated times",
                 n_late_fires, n_res_sat, n_time_sat);
        if (pending_decisions.size() != 0) begin
            mismatches += pending_decisions.size();
            $display("%0d expected decisions never arrived", pending_decisions.size());
        end
        if (mismatches > 10)
            $display("%0d mismatches in total", mismatches);
        if (mismatches == 0) begin
            $display("bsa_spike_encoder_unit regression: pass");
        end else begin
            $display("bsa_spike_encoder_unit regression: fail");
        end
        $finish;
    end

endmodule
